/* sv/packed_date_plus_elapsed_seconds_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the packed date plus elapsed seconds block
// ----------------------------------------------------------------------------
`ifndef PACKED_DATE_PLUS_ELAPSED_SECONDS_MACROS_SVH
`define PACKED_DATE_PLUS_ELAPSED_SECONDS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PDPES_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PDPES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pdpes_pkg.sv */
// ----------------------------------------------------------------------------
// pdpes_pkg
// types, constants and calendar functions of the packed date adder
// ----------------------------------------------------------------------------
package pdpes_pkg;

    localparam int unsigned PACK_W    = 34;
    localparam int unsigned EL_W      = 25;
    localparam int unsigned FLD_W     = 7;
    localparam int unsigned SEC_W     = 6;
    localparam int unsigned DIV_W     = 35;
    localparam int unsigned DIV_STEP  = 7;
    localparam int unsigned DIV_CYC   = DIV_W / DIV_STEP;
    localparam int unsigned DVS_W     = 7;
    localparam int unsigned ACC_W     = 26;
    localparam int unsigned DAY_W     = 9;
    localparam int unsigned MON_W     = 4;
    localparam int unsigned NUM_PAIRS = 5;
    localparam int unsigned NUM_TDIV  = 3;
    localparam int unsigned CNT_W     = 3;

    localparam logic [EL_W-1:0]  C_EL_MAX    = 25'd31535999;
    localparam logic [DVS_W-1:0] C_DIV_DEC   = 7'd100;
    localparam logic [DVS_W-1:0] C_DIV_MIN   = 7'd60;
    localparam logic [DVS_W-1:0] C_DIV_HOUR  = 7'd24;
    localparam logic [ACC_W-1:0] C_SEC_DAY   = 26'd86400;
    localparam logic [ACC_W-1:0] C_SEC_HOUR  = 26'd3600;
    localparam logic [ACC_W-1:0] C_SEC_MIN   = 26'd60;
    localparam logic [ACC_W-1:0] C_YLEN      = 26'd31536000;
    localparam logic [ACC_W-1:0] C_YLEN_LEAP = 26'd31622400;
    localparam logic [FLD_W-1:0] C_YEAR_LIM  = 7'd50;
    localparam logic [FLD_W-1:0] C_HOUR_LIM  = 7'd24;
    localparam logic [FLD_W-1:0] C_MIN_LIM   = 7'd60;
    localparam logic [MON_W-1:0] C_LAST_MON  = 4'd12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_CHECK,
        ST_ACC_H,
        ST_ACC_M,
        ST_ROLL,
        ST_TSTART,
        ST_TSPLIT,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DVS_W-1:0] divisor;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [4:0] month_days(input logic [MON_W-1:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // days in the months before m
    function automatic logic [DAY_W-1:0] days_before(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

/* sv/pdpes_if.sv */
// ----------------------------------------------------------------------------
// pdpes channel interfaces
// valid/ready channels for the packed date input and the calendar result
// ----------------------------------------------------------------------------
interface pdpes_in_if;
    import pdpes_pkg::*;

    logic              valid;
    logic              ready;
    logic [PACK_W-1:0] packed_datetime;
    logic [EL_W-1:0]   elapsed_seconds;

    modport source (output valid, output packed_datetime, output elapsed_seconds,
                    input ready);
    modport sink   (input valid, input packed_datetime, input elapsed_seconds,
                    output ready);
endinterface

interface pdpes_out_if;
    import pdpes_pkg::*;

    logic             valid;
    logic             ready;
    logic             valid_res;
    logic [FLD_W-1:0] year;
    logic [FLD_W-1:0] month;
    logic [FLD_W-1:0] day;
    logic [FLD_W-1:0] hour;
    logic [FLD_W-1:0] minute;
    logic [SEC_W-1:0] second;

    modport source (output valid, output valid_res, output year, output month,
                    output day, output hour, output minute, output second,
                    input ready);
    modport sink   (input valid, input valid_res, input year, input month,
                    input day, input hour, input minute, input second,
                    output ready);
endinterface

/* sv/pdpes_div.sv */
// ----------------------------------------------------------------------------
// pdpes_div
// shared restoring divider by a small divisor, several quotient bits a cycle
// ----------------------------------------------------------------------------
module pdpes_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdpes_pkg::t_div_req i_req,
    output pdpes_pkg::t_div_rsp o_rsp
);
    import pdpes_pkg::*;

    localparam int unsigned DCNT_W = $clog2(DIV_CYC + 1);

    logic [DIV_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W-1:0]  n_q;
    logic [DVS_W-1:0]  n_rem;
    logic [DVS_W:0]    v_t;

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        v_t   = '0;
        for (int i = 0; i < int'(DIV_STEP); i++) begin
            v_t = {n_rem, n_q[DIV_W-1]};
            n_q = {n_q[DIV_W-2:0], 1'b0};
            if (v_t >= {1'b0, r_dvs}) begin
                v_t    = v_t - {1'b0, r_dvs};
                n_q[0] = 1'b1;
            end
            n_rem = v_t[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_CYC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

/* sv/packed_date_plus_elapsed_seconds.sv */
// ----------------------------------------------------------------------------
// packed_date_plus_elapsed_seconds: adds elapsed seconds to a yymmddhhnn date
// one item at a time; the shared divider splits off the five decimal pairs,
// then seconds, minutes and hours, and a month walk finds month and day;
// a rejected date goes straight from the check to the result
// reset (synchronous, active low) idles the sequencer and empties the result
// ----------------------------------------------------------------------------
`include "packed_date_plus_elapsed_seconds_macros.svh"

module packed_date_plus_elapsed_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdpes_in_if.sink    i_in_ch,
    pdpes_out_if.source o_out_ch
);
    import pdpes_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    logic [FLD_W-1:0]  r_pair [NUM_PAIRS];
    logic [FLD_W-1:0]  r_tp   [NUM_TDIV];
    logic [EL_W-1:0]   r_el;
    logic [ACC_W-1:0]  r_acc;
    logic [FLD_W-1:0]  r_yy;
    logic              r_leap;
    logic              r_ok;
    logic [DAY_W-1:0]  r_rest;
    logic [MON_W-1:0]  r_mon;

    logic              r_out_valid;
    logic              r_o_valid_res;
    logic [FLD_W-1:0]  r_o_year;
    logic [FLD_W-1:0]  r_o_month;
    logic [FLD_W-1:0]  r_o_day;
    logic [FLD_W-1:0]  r_o_hour;
    logic [FLD_W-1:0]  r_o_minute;
    logic [SEC_W-1:0]  r_o_second;

    logic              w_accept;
    logic              w_pairs_last;
    logic              w_tdiv_last;
    logic              w_chk_leap;
    logic              w_ok;
    logic [DAY_W-1:0]  w_days;
    logic [ACC_W-1:0]  w_ylen;
    logic [FLD_W-1:0]  w_yy_inc;
    logic [4:0]        w_walk_md;
    logic              w_walk_go;
    logic              w_load_out;

    pdpes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_accept     = i_in_ch.valid && i_in_ch.ready;
    assign w_pairs_last = (r_cnt == CNT_W'(NUM_PAIRS - 1));
    assign w_tdiv_last  = (r_cnt == CNT_W'(NUM_TDIV - 1));

    // pairs after the split: 0 minute, 1 hour, 2 day, 3 month, 4 year
    assign w_chk_leap = (r_pair[4][1:0] == 2'b00);
    assign w_ok = (r_pair[4] < C_YEAR_LIM) &&
                  (r_pair[3] >= 7'd1) && (r_pair[3] <= {3'b000, C_LAST_MON}) &&
                  (r_pair[2] >= 7'd1) &&
                  (r_pair[2] <= {2'b00, month_days(r_pair[3][MON_W-1:0], w_chk_leap)}) &&
                  (r_pair[1] < C_HOUR_LIM) && (r_pair[0] < C_MIN_LIM);
    assign w_days = DAY_W'(r_pair[2]) + days_before(r_pair[3][MON_W-1:0], w_chk_leap);

    assign w_ylen   = r_leap ? C_YLEN_LEAP : C_YLEN;
    assign w_yy_inc = r_yy + 7'd1;

    assign w_walk_md = month_days(r_mon, r_leap);
    assign w_walk_go = (r_mon < C_LAST_MON) && (r_rest > DAY_W'(w_walk_md));

    assign w_load_out = (r_state == ST_FINISH) && (!r_out_valid || o_out_ch.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_ch.valid) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (w_div_rsp.done && w_pairs_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_ok ? ST_ACC_H : ST_FINISH;
            end
            ST_ACC_H:   n_state = ST_ACC_M;
            ST_ACC_M:   n_state = ST_ROLL;
            ST_ROLL:    n_state = ST_TSTART;
            ST_TSTART:  n_state = ST_TSPLIT;
            ST_TSPLIT: begin
                if (w_div_rsp.done && w_tdiv_last) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!w_walk_go) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: divider requests and input ready
    always_comb begin
        i_in_ch.ready      = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.divisor  = C_DIV_DEC;
        w_div_req.dividend = w_div_rsp.quot;
        case (r_state)
            ST_IDLE: begin
                i_in_ch.ready      = 1'b1;
                w_div_req.start    = i_in_ch.valid;
                w_div_req.dividend = DIV_W'(i_in_ch.packed_datetime);
            end
            ST_SPLIT: begin
                w_div_req.start = w_div_rsp.done && !w_pairs_last;
            end
            ST_TSTART: begin
                w_div_req.start    = 1'b1;
                w_div_req.divisor  = C_DIV_MIN;
                w_div_req.dividend = DIV_W'(r_acc);
            end
            ST_TSPLIT: begin
                w_div_req.start   = w_div_rsp.done && !w_tdiv_last;
                w_div_req.divisor = (r_cnt == CNT_W'(NUM_TDIV - 2)) ? C_DIV_HOUR : C_DIV_MIN;
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept || (r_state == ST_TSTART)) begin
                r_cnt <= '0;
            end else if (w_div_rsp.done) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_el <= (i_in_ch.elapsed_seconds > C_EL_MAX) ? C_EL_MAX
                                                                 : i_in_ch.elapsed_seconds;
                end
            end
            ST_SPLIT: begin
                if (w_div_rsp.done) begin
                    r_pair[NUM_PAIRS-1] <= w_div_rsp.rem;
                    for (int k = 0; k < int'(NUM_PAIRS) - 1; k++) begin
                        r_pair[k] <= r_pair[k+1];
                    end
                end
            end
            ST_CHECK: begin
                r_ok   <= w_ok;
                r_leap <= w_chk_leap;
                r_yy   <= r_pair[4];
                r_acc  <= C_SEC_DAY * ACC_W'(w_days - 9'd1);
            end
            ST_ACC_H: begin
                r_acc <= r_acc + C_SEC_HOUR * ACC_W'(r_pair[1]);
            end
            ST_ACC_M: begin
                r_acc <= r_acc + C_SEC_MIN * ACC_W'(r_pair[0]) + ACC_W'(r_el);
            end
            ST_ROLL: begin
                // one rollover at most, the elapsed count is under a year
                if (r_acc >= w_ylen) begin
                    r_acc  <= r_acc - w_ylen;
                    r_yy   <= w_yy_inc;
                    r_leap <= (w_yy_inc[1:0] == 2'b00);
                end
            end
            ST_TSPLIT: begin
                if (w_div_rsp.done) begin
                    r_tp[NUM_TDIV-1] <= w_div_rsp.rem;
                    for (int k = 0; k < int'(NUM_TDIV) - 1; k++) begin
                        r_tp[k] <= r_tp[k+1];
                    end
                    if (w_tdiv_last) begin
                        r_rest <= w_div_rsp.quot[DAY_W-1:0] + 9'd1;
                        r_mon  <= 4'd1;
                    end
                end
            end
            ST_WALK: begin
                if (w_walk_go) begin
                    r_rest <= r_rest - DAY_W'(w_walk_md);
                    r_mon  <= r_mon + 4'd1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_valid_res <= r_ok;
            if (r_ok) begin
                r_o_year   <= r_yy;
                r_o_month  <= FLD_W'(r_mon);
                r_o_day    <= r_rest[FLD_W-1:0];
                r_o_hour   <= r_tp[2];
                r_o_minute <= r_tp[1];
                r_o_second <= r_tp[0][SEC_W-1:0];
            end else begin
                r_o_year   <= r_pair[4];
                r_o_month  <= r_pair[3];
                r_o_day    <= r_pair[2];
                r_o_hour   <= r_pair[1];
                r_o_minute <= r_pair[0];
                r_o_second <= '0;
            end
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.valid_res = r_o_valid_res;
    assign o_out_ch.year      = r_o_year;
    assign o_out_ch.month     = r_o_month;
    assign o_out_ch.day       = r_o_day;
    assign o_out_ch.hour      = r_o_hour;
    assign o_out_ch.minute    = r_o_minute;
    assign o_out_ch.second    = r_o_second;

    `PDPES_ASSERT_SAME(a_div_done_waited, i_clk, i_rst_n, w_div_rsp.done, (r_state == ST_SPLIT) || (r_state == ST_TSPLIT), "divider finished while the sequencer was not waiting")
    `PDPES_ASSERT_SAME(a_walk_month_range, i_clk, i_rst_n, r_state == ST_WALK, (r_mon >= 4'd1) && (r_mon <= C_LAST_MON) && (r_rest >= 9'd1), "month walk left the calendar")
    `PDPES_ASSERT_SAME(a_result_in_range, i_clk, i_rst_n, o_out_ch.valid && o_out_ch.valid_res, (o_out_ch.month >= 7'd1) && (o_out_ch.month <= 7'd12) && (o_out_ch.day >= 7'd1) && (o_out_ch.day <= 7'd31) && (o_out_ch.hour < 7'd24) && (o_out_ch.minute < 7'd60) && (o_out_ch.second < 6'd60), "valid result out of calendar range")
    `PDPES_ASSERT_SAME(a_reject_second_zero, i_clk, i_rst_n, o_out_ch.valid && !o_out_ch.valid_res, o_out_ch.second == 6'd0, "rejected date with non-zero second")
    `PDPES_ASSERT_NEXT(a_accept_starts_split, i_clk, i_rst_n, w_accept, (r_state == ST_SPLIT) && w_div_rsp.busy, "transfer did not start the decimal split")

endmodule

/* dv/tb_packed_date_plus_elapsed_seconds.sv */
// ----------------------------------------------------------------------------
// tb_packed_date_plus_elapsed_seconds
// Drives packed yymmddhhnn dates with elapsed second counts into the block.
// A calendar model in the bench predicts each result and a monitor compares
// every result transfer with it, field by field. The runs use random sender
// bursts and receiver stall patterns, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_packed_date_plus_elapsed_seconds;
    timeunit 1ns;
    timeprecision 1ps;

    import pdpes_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic             valid_res;
        logic [FLD_W-1:0] year;
        logic [FLD_W-1:0] month;
        logic [FLD_W-1:0] day;
        logic [FLD_W-1:0] hour;
        logic [FLD_W-1:0] minute;
        logic [SEC_W-1:0] second;
    } t_calendar;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdpes_in_if  in_ch ();
    pdpes_out_if out_ch ();

    t_calendar   pending_results[$];
    int unsigned error_count = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;
    bit          hold_req    = 1'b0;
    bit          hold_off    = 1'b0;

    packed_date_plus_elapsed_seconds u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------------
    function automatic int unsigned month_len(input int unsigned m, input bit leap);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            1, 3, 5, 7, 8,
            10, 12:        return 31;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [PACK_W-1:0] pack_date(input longint unsigned yy,
                                                    input longint unsigned mo,
                                                    input longint unsigned dd,
                                                    input longint unsigned hh,
                                                    input longint unsigned mi);
        longint unsigned v;
        v = yy * 64'd100000000 + mo * 64'd1000000 + dd * 64'd10000 + hh * 64'd100 + mi;
        return v[PACK_W-1:0];
    endfunction

    function automatic t_calendar add_elapsed(input logic [PACK_W-1:0] stamp,
                                              input logic [EL_W-1:0] elapsed);
        t_calendar       r;
        longint unsigned rest_p;
        int unsigned     yy, mo, dd, hh, mi, el, days, soy, ylen, m;
        bit              leap;
        r      = '0;
        rest_p = stamp;
        el     = (elapsed > C_EL_MAX) ? C_EL_MAX : elapsed;
        mi = rest_p % 100; rest_p = rest_p / 100;
        hh = rest_p % 100; rest_p = rest_p / 100;
        dd = rest_p % 100; rest_p = rest_p / 100;
        mo = rest_p % 100; rest_p = rest_p / 100;
        yy = rest_p % 100;
        leap = (yy % 4) == 0;
        if (!(yy < 50 && mo >= 1 && mo <= 12 && dd >= 1 && dd <= month_len(mo, leap)
              && hh < 24 && mi < 60)) begin
            // rejected date: raw pairs back, elapsed count ignored
            r.year   = yy;
            r.month  = mo;
            r.day    = dd;
            r.hour   = hh;
            r.minute = mi;
            return r;
        end
        days = dd;
        for (m = 1; m < mo; m++) begin
            days += month_len(m, leap);
        end
        soy  = 86400 * (days - 1) + 3600 * hh + 60 * mi + el;
        ylen = leap ? 31622400 : 31536000;
        if (soy >= ylen) begin
            yy++;
            soy -= ylen;
            leap = (yy % 4) == 0;
        end
        r.second = soy % 60; soy = soy / 60;
        r.minute = soy % 60; soy = soy / 60;
        r.hour   = soy % 24; soy = soy / 24;
        days = soy + 1;
        m    = 1;
        while (m < 12 && days > month_len(m, leap)) begin
            days -= month_len(m, leap);
            m++;
        end
        r.valid_res = 1'b1;
        r.year      = yy;
        r.month     = m;
        r.day       = days;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side: bursts with random gaps, valid held across back-to-back items
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [PACK_W-1:0] stamp, input logic [EL_W-1:0] elapsed);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            case ($urandom_range(7, 0))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(80, 9);
                default: gap = $urandom_range(8, 1);
            endcase
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_ch.valid           <= 1'b1;
        in_ch.packed_datetime <= stamp;
        in_ch.elapsed_seconds <= elapsed;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(add_elapsed(stamp, elapsed));
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic logic [EL_W-1:0] rand_elapsed();
        case ($urandom_range(3, 0))
            0:       return $urandom_range(C_EL_MAX, 0);
            1:       return $urandom_range(100000, 0);
            2:       return $urandom_range(C_EL_MAX, C_EL_MAX - 100000);
            default: return $urandom_range(33554431, 0);   // includes saturating counts
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // output side: stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------------
    initial begin : drive_ready
        int unsigned mode, left;
        out_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(2, 0);
                left = $urandom_range(200, 20);
            end
            left--;
            case (mode)
                0:       out_ch.ready <= !hold_off;
                1:       out_ch.ready <= !hold_off && ($urandom_range(1, 0) == 1);
                default: out_ch.ready <= !hold_off && ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    initial begin : long_hold
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_calendar want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expected result pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("valid_res", want.valid_res, out_ch.valid_res);
                check_field("year",      want.year,      out_ch.year);
                check_field("month",     want.month,     out_ch.month);
                check_field("day",       want.day,       out_ch.day);
                check_field("hour",      want.hour,      out_ch.hour);
                check_field("minute",    want.minute,    out_ch.minute);
                check_field("second",    want.second,    out_ch.second);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_item('0, '0);                                          // all-zero pairs
        send_item(pack_date(0, 1, 1, 0, 0), '0);                    // earliest valid
        send_item(pack_date(49, 12, 31, 23, 59), '1);               // saturating, rolls to 50
        send_item(pack_date(0, 2, 29, 12, 30), 25'd12345);          // leap day
        send_item(pack_date(1, 2, 29, 0, 0), 25'd500);              // no leap day in 01
        send_item(pack_date(4, 2, 30, 0, 0), 25'd500);
        send_item(pack_date(50, 1, 1, 0, 0), 25'd500);              // year out of range
        send_item(pack_date(10, 0, 1, 0, 0), 25'd500);
        send_item(pack_date(10, 13, 1, 0, 0), 25'd500);
        send_item(pack_date(10, 1, 0, 0, 0), 25'd500);
        send_item(pack_date(10, 4, 31, 0, 0), 25'd500);
        send_item(pack_date(10, 1, 1, 24, 0), 25'd500);
        send_item(pack_date(10, 1, 1, 0, 60), 25'd500);
        send_item('1, '1);                                          // all ones
        send_item(pack_date(112, 6, 15, 8, 30), 25'd777);           // digits above the year
        send_item(pack_date(3, 12, 31, 23, 59), 25'd59);            // one short of rollover
        send_item(pack_date(3, 12, 31, 23, 59), 25'd60);            // sum equals year length
        send_item(pack_date(3, 6, 1, 0, 0), C_EL_MAX);              // into a leap year
        send_item(pack_date(4, 1, 1, 0, 0), C_EL_MAX);
        send_item(pack_date(8, 12, 31, 23, 59), 25'd60);            // leap year length
        send_item(pack_date(99, 99, 99, 99, 99), 25'd1);
        send_item(pack_date(7, 2, 28, 23, 59), 25'd60);
        send_item(pack_date(48, 2, 28, 23, 59), 25'd60);
        send_item(pack_date(20, 1, 1, 0, 0), C_EL_MAX + 25'd1);
    endtask

    task automatic test_random_valid(input int unsigned count);
        int unsigned yy, mo, dd, hh, mi;
        repeat (count) begin
            yy = $urandom_range(49, 0);
            mo = ($urandom_range(3, 0) == 0) ? (($urandom_range(1, 0) == 0) ? 2 : 12)
                                             : $urandom_range(12, 1);
            dd = ($urandom_range(3, 0) == 0) ? month_len(mo, (yy % 4) == 0)
                                             : $urandom_range(month_len(mo, (yy % 4) == 0), 1);
            hh = $urandom_range(23, 0);
            mi = $urandom_range(59, 0);
            send_item(pack_date(yy, mo, dd, hh, mi), rand_elapsed());
        end
    endtask

    task automatic test_broken_dates(input int unsigned count);
        int unsigned yy, mo, dd, hh, mi;
        logic [PACK_W-1:0] noise;
        repeat (count) begin
            if ($urandom_range(1, 0) == 0) begin
                noise = {$urandom_range(3, 0), $urandom()};
                send_item(noise, $urandom_range(33554431, 0));
            end else begin
                yy = $urandom_range(49, 0);
                mo = $urandom_range(12, 1);
                dd = $urandom_range(month_len(mo, (yy % 4) == 0), 1);
                hh = $urandom_range(23, 0);
                mi = $urandom_range(59, 0);
                case ($urandom_range(6, 0))
                    0:       yy = $urandom_range(99, 50);
                    1:       mo = 0;
                    2:       mo = $urandom_range(99, 13);
                    3:       dd = 0;
                    4:       dd = $urandom_range(99, month_len(mo, (yy % 4) == 0) + 1);
                    5:       hh = $urandom_range(99, 24);
                    default: mi = $urandom_range(99, 60);
                endcase
                send_item(pack_date(yy, mo, dd, hh, mi), rand_elapsed());
            end
        end
    endtask

    task automatic test_backpressure(input int unsigned count);
        hold_req   = 1'b1;
        burst_left = count;   // offer every item back to back, the output starting with a long hold
        test_random_valid(count);
    endtask

    initial begin
        in_ch.valid           = 1'b0;
        in_ch.packed_datetime = '0;
        in_ch.elapsed_seconds = '0;
        i_rst_n               = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_valid(500);
        test_broken_dates(140);
        test_backpressure(40);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* packed_date_plus_elapsed_seconds.f */
+incdir+sv
sv/pdpes_pkg.sv
sv/pdpes_if.sv
sv/pdpes_div.sv
sv/packed_date_plus_elapsed_seconds.sv
dv/tb_packed_date_plus_elapsed_seconds.sv
